### rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, constants and helpers for the rectangle polygon clipper.
// ----------------------------------------------------------------------------
package prc_pkg;

	localparam int MaxInVerts = 16;
	localparam int ListDepth  = 32;
	localparam int MaxOut     = 32;
	localparam int AddrW      = $clog2(ListDepth);
	localparam int CntW       = $clog2(ListDepth + 1);
	localparam int NumPasses  = 4;
	localparam int PassW      = 3;
	localparam int NumW       = 34;
	localparam int DenW       = 17;

	localparam logic [1:0] REG_XMIN = 2'd0;
	localparam logic [1:0] REG_YMIN = 2'd1;
	localparam logic [1:0] REG_XMAX = 2'd2;
	localparam logic [1:0] REG_YMAX = 2'd3;

	localparam logic [1:0] PASS_TOP    = 2'd0;
	localparam logic [1:0] PASS_RIGHT  = 2'd1;
	localparam logic [1:0] PASS_BOTTOM = 2'd2;
	localparam logic [1:0] PASS_LEFT   = 2'd3;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PSTART,
		ST_RD0,
		ST_RD0W,
		ST_RDN,
		ST_RDNW,
		ST_EDGE,
		ST_MUL,
		ST_DIVS,
		ST_DIV,
		ST_PUSHX,
		ST_PUSHP,
		ST_ADV,
		ST_PEND,
		ST_ERD,
		ST_EOUT
	} state_t;

	typedef struct packed {
		logic             load_we;
		logic             cap_first;
		logic             cap_cur;
		logic             use_first;
		logic             mul_go;
		logic             div_start;
		logic             push_x;
		logic             push_p;
		logic             adv;
		logic             out_load;
		logic             out_empty;
		logic             out_last;
		logic             ovf;
		logic [1:0]       pass;
		logic [AddrW-1:0] rd_addr;
		logic [AddrW-1:0] wr_addr;
	} cmd_t;

	typedef struct packed {
		logic sin;
		logic pin;
		logic div_done;
	} status_t;

	function automatic logic is_inside(input logic [1:0] pass,
			input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] xmin, input logic signed [15:0] ymin,
			input logic signed [15:0] xmax, input logic signed [15:0] ymax);
		logic r;
		case (pass)
			PASS_TOP:    r = (y >= ymin);
			PASS_RIGHT:  r = (x <= xmax);
			PASS_BOTTOM: r = (y <= ymax);
			default:     r = (x >= xmin);
		endcase
		return r;
	endfunction

endpackage

### rtl/prc_ram.sv
// ----------------------------------------------------------------------------
// prc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prc_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/prc_div.sv
// ----------------------------------------------------------------------------
// prc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [prc_pkg::NumW-1:0]    num,
	input  logic [prc_pkg::DenW-1:0]    den,
	output logic                        done,
	output logic [prc_pkg::NumW-1:0]    quo
);

	localparam int StepW = $clog2(prc_pkg::NumW);

	logic                      busy_q;
	logic                      done_q;
	logic [StepW-1:0]          step_q;
	logic [prc_pkg::DenW:0]    rem_q;
	logic [prc_pkg::DenW-1:0]  den_q;
	logic [prc_pkg::NumW-1:0]  quo_q;
	logic [prc_pkg::DenW:0]    trial;
	logic                      ge;

	assign trial = {rem_q[prc_pkg::DenW-1:0], quo_q[prc_pkg::NumW-1]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(prc_pkg::NumW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[prc_pkg::NumW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/prc_datapath.sv
// ----------------------------------------------------------------------------
// prc_datapath
// Window registers, vertex lists, edge registers, crossing arithmetic and
// output register.
// ----------------------------------------------------------------------------
module prc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [31:0]         vin,
	input  prc_pkg::cmd_t       cmd,
	output prc_pkg::status_t    sts,
	output logic [31:0]         out_xy,
	output logic                out_last,
	output logic [1:0]          out_flags
);

	logic signed [15:0] xmin_q, ymin_q, xmax_q, ymax_q;
	logic [31:0] first_q, prev_q, cur_q;
	logic [31:0] rd_a, rd_b, rdata, wdata;
	logic        we_a, we_b;
	logic signed [15:0] px, py, cx, cy, c0, c1, o0, o1, bnd;
	logic signed [16:0] db, dob, dden;
	logic signed [33:0] prod;
	logic signed [33:0] prod_s1;
	logic signed [16:0] den_s1;
	logic signed [15:0] o0_s1, bnd_s1;
	logic [prc_pkg::NumW-1:0] num_mag, quo;
	logic [prc_pkg::DenW-1:0] den_mag;
	logic        div_done;
	logic [15:0] qv, cross_o;
	logic [31:0] cross_xy;
	logic [31:0] oxy_q;
	logic        olast_q, oempty_q, oovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xmin_q <= 16'sd0;
			ymin_q <= 16'sd0;
			xmax_q <= 16'sd639;
			ymax_q <= 16'sd479;
		end else if (cfg_we) begin
			case (cfg_index)
				prc_pkg::REG_XMIN: xmin_q <= cfg_data;
				prc_pkg::REG_YMIN: ymin_q <= cfg_data;
				prc_pkg::REG_XMAX: xmax_q <= cfg_data;
				prc_pkg::REG_YMAX: ymax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// odd passes read bank b and write bank a, even passes the other way
	assign we_a  = cmd.load_we | ((cmd.push_x | cmd.push_p) & cmd.pass[0]);
	assign we_b  = (cmd.push_x | cmd.push_p) & ~cmd.pass[0];
	assign wdata = cmd.load_we ? vin : (cmd.push_x ? cross_xy : cur_q);
	assign rdata = cmd.pass[0] ? rd_b : rd_a;

	prc_ram #(.Width(32), .Depth(prc_pkg::ListDepth)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cmd.wr_addr),
		.wdata (wdata),
		.raddr (cmd.rd_addr),
		.rdata (rd_a)
	);

	prc_ram #(.Width(32), .Depth(prc_pkg::ListDepth)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cmd.wr_addr),
		.wdata (wdata),
		.raddr (cmd.rd_addr),
		.rdata (rd_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_first) begin
			first_q <= rdata;
			prev_q  <= rdata;
		end
		if (cmd.cap_cur) begin
			cur_q <= cmd.use_first ? first_q : rdata;
		end
		if (cmd.adv) begin
			prev_q <= cur_q;
		end
	end

	assign px = prev_q[15:0];
	assign py = prev_q[31:16];
	assign cx = cur_q[15:0];
	assign cy = cur_q[31:16];

	assign sts.sin = prc_pkg::is_inside(cmd.pass, px, py, xmin_q, ymin_q, xmax_q, ymax_q);
	assign sts.pin = prc_pkg::is_inside(cmd.pass, cx, cy, xmin_q, ymin_q, xmax_q, ymax_q);
	assign sts.div_done = div_done;

	// horizontal boundaries test y and solve for x, vertical ones the reverse
	always_comb begin
		case (cmd.pass)
			prc_pkg::PASS_TOP:    bnd = ymin_q;
			prc_pkg::PASS_RIGHT:  bnd = xmax_q;
			prc_pkg::PASS_BOTTOM: bnd = ymax_q;
			default:              bnd = xmin_q;
		endcase
	end

	assign c0 = cmd.pass[0] ? px : py;
	assign c1 = cmd.pass[0] ? cx : cy;
	assign o0 = cmd.pass[0] ? py : px;
	assign o1 = cmd.pass[0] ? cy : cx;

	assign db   = 17'(bnd) - 17'(c0);
	assign dob  = 17'(o1) - 17'(o0);
	assign dden = 17'(c1) - 17'(c0);
	assign prod = db * dob;

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= prod;
			den_s1  <= dden;
			o0_s1   <= o0;
			bnd_s1  <= bnd;
		end
	end

	assign num_mag = prod_s1[33] ? 34'(-prod_s1) : 34'(prod_s1);
	assign den_mag = den_s1[16] ? 17'(-den_s1) : 17'(den_s1);

	prc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_mag),
		.den    (den_mag),
		.done   (div_done),
		.quo    (quo)
	);

	// truncation toward zero: negate the magnitude quotient
	assign qv       = (prod_s1[33] ^ den_s1[16]) ? (16'd0 - quo[15:0]) : quo[15:0];
	assign cross_o  = o0_s1 + qv;
	assign cross_xy = cmd.pass[0] ? {cross_o, bnd_s1} : {bnd_s1, cross_o};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			oxy_q    <= cmd.out_empty ? 32'd0 : rdata;
			olast_q  <= cmd.out_last;
			oempty_q <= cmd.out_empty;
			oovf_q   <= cmd.ovf;
		end
	end

	assign out_xy    = oxy_q;
	assign out_last  = olast_q;
	assign out_flags = {oovf_q, oempty_q};

endmodule

### rtl/prc_ctrl.sv
// ----------------------------------------------------------------------------
// prc_ctrl
// Sequencer for loading, the four clip passes and emission of results.
// ----------------------------------------------------------------------------
module prc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  prc_pkg::status_t     sts,
	output prc_pkg::cmd_t        cmd
);

	localparam int CW = prc_pkg::CntW;
	localparam int AW = prc_pkg::AddrW;

	prc_pkg::state_t state_q, state_d;
	logic [CW-1:0] n_q, n_d, j_q, j_d, k_q, k_d;
	logic [prc_pkg::PassW-1:0] pass_q, pass_d;
	logic ovf_q, ovf_d;
	logic [CW-1:0] j_inc;
	// output register fills the cycle after the read address is issued
	logic eload_q;
	logic elast_q;

	assign j_inc = j_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prc_pkg::ST_LOAD;
			n_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			pass_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			j_q     <= j_d;
			k_q     <= k_d;
			pass_q  <= pass_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		j_d       = j_q;
		k_d       = k_q;
		pass_d    = pass_q;
		ovf_d     = ovf_q;
		cmd       = '0;
		cmd.pass  = pass_q[1:0];
		cmd.ovf   = ovf_q;
		cmd.rd_addr = j_q[AW-1:0];
		cmd.wr_addr = k_q[AW-1:0];
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			prc_pkg::ST_LOAD: begin
				in_ready    = 1'b1;
				cmd.wr_addr = n_q[AW-1:0];
				if (in_valid) begin
					if (n_q < CW'(prc_pkg::MaxInVerts) && n_q < CW'(prc_pkg::ListDepth)) begin
						cmd.load_we = 1'b1;
						n_d = n_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (in_last) begin
						pass_d  = '0;
						state_d = prc_pkg::ST_PSTART;
					end
				end
			end
			prc_pkg::ST_PSTART: begin
				j_d = '0;
				k_d = '0;
				state_d = (n_q == '0) ? prc_pkg::ST_PEND : prc_pkg::ST_RD0;
			end
			prc_pkg::ST_RD0: begin
				cmd.rd_addr = '0;
				state_d = prc_pkg::ST_RD0W;
			end
			prc_pkg::ST_RD0W: begin
				cmd.cap_first = 1'b1;
				state_d = prc_pkg::ST_RDN;
			end
			prc_pkg::ST_RDN: begin
				cmd.rd_addr = j_inc[AW-1:0];
				state_d = prc_pkg::ST_RDNW;
			end
			prc_pkg::ST_RDNW: begin
				cmd.cap_cur   = 1'b1;
				cmd.use_first = (j_inc == n_q);
				state_d = prc_pkg::ST_EDGE;
			end
			prc_pkg::ST_EDGE: begin
				if (sts.sin != sts.pin) begin
					state_d = prc_pkg::ST_MUL;
				end else if (sts.pin) begin
					state_d = prc_pkg::ST_PUSHP;
				end else begin
					state_d = prc_pkg::ST_ADV;
				end
			end
			prc_pkg::ST_MUL: begin
				cmd.mul_go = 1'b1;
				state_d = prc_pkg::ST_DIVS;
			end
			prc_pkg::ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d = prc_pkg::ST_DIV;
			end
			prc_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_d = prc_pkg::ST_PUSHX;
				end
			end
			prc_pkg::ST_PUSHX: begin
				if (k_q < CW'(prc_pkg::ListDepth)) begin
					cmd.push_x = 1'b1;
					k_d = k_q + 1'b1;
				end else begin
					ovf_d = 1'b1;
				end
				state_d = sts.pin ? prc_pkg::ST_PUSHP : prc_pkg::ST_ADV;
			end
			prc_pkg::ST_PUSHP: begin
				if (k_q < CW'(prc_pkg::ListDepth)) begin
					cmd.push_p = 1'b1;
					k_d = k_q + 1'b1;
				end else begin
					ovf_d = 1'b1;
				end
				state_d = prc_pkg::ST_ADV;
			end
			prc_pkg::ST_ADV: begin
				cmd.adv = 1'b1;
				j_d = j_inc;
				state_d = (j_inc == n_q) ? prc_pkg::ST_PEND : prc_pkg::ST_RDN;
			end
			prc_pkg::ST_PEND: begin
				n_d = k_q;
				j_d = '0;
				if (pass_q == prc_pkg::PassW'(prc_pkg::NumPasses - 1)) begin
					// even number of passes: the result sits in bank a again
					pass_d = '0;
					if (k_q == '0) begin
						cmd.out_load  = 1'b1;
						cmd.out_empty = 1'b1;
						cmd.out_last  = 1'b1;
						state_d = prc_pkg::ST_EOUT;
					end else begin
						state_d = prc_pkg::ST_ERD;
					end
				end else begin
					pass_d  = pass_q + 1'b1;
					state_d = prc_pkg::ST_PSTART;
				end
			end
			prc_pkg::ST_ERD: begin
				state_d = prc_pkg::ST_EOUT;
				cmd.rd_addr = j_q[AW-1:0];
				if (n_q > CW'(prc_pkg::MaxOut)) begin
					ovf_d = 1'b1;
				end
			end
			prc_pkg::ST_EOUT: begin
				if (eload_q) begin
					// read data has arrived: fill the output register first
					cmd.out_load = 1'b1;
					cmd.out_last = elast_q;
				end else begin
					out_valid = 1'b1;
					if (out_ready) begin
						if (n_q == '0 || j_inc == n_q || j_inc == CW'(prc_pkg::MaxOut)) begin
							n_d     = '0;
							j_d     = '0;
							ovf_d   = 1'b0;
							state_d = prc_pkg::ST_LOAD;
						end else begin
							j_d     = j_inc;
							state_d = prc_pkg::ST_ERD;
						end
					end
				end
			end
			default: state_d = prc_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eload_q <= 1'b0;
			elast_q <= 1'b0;
		end else begin
			eload_q <= (state_q == prc_pkg::ST_ERD);
			elast_q <= (j_inc == n_q) || (j_inc == CW'(prc_pkg::MaxOut));
		end
	end

endmodule

### rtl/polygon_rect_clipper_top.sv
// ----------------------------------------------------------------------------
// polygon_rect_clipper_top
// Sutherland-Hodgman clipper of a closed polygon against a rectangle window.
// ----------------------------------------------------------------------------
// Vertices load at one per cycle; the one with tlast closes the polygon and
// starts four clip passes (top, right, bottom, left). In each pass, every
// edge that crosses the boundary runs the bit-serial divider that finds the
// crossing point. Results then leave one at a time, each read from the list
// only after the one before has been accepted, the final one with tlast; a
// polygon clipped away gives one item with the empty flag set. No new vertex
// is taken from the end of loading until the last result has been accepted.
module polygon_rect_clipper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // vertex_x, vertex_y
	input  logic        s_tlast,   // final_vertex
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_x, out_y
	output logic        m_tlast,   // out_last
	output logic [1:0]  m_tuser    // clipped_away, store_overflow
);

	prc_pkg::cmd_t    cmd;
	prc_pkg::status_t sts;

	prc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	prc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vin       (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_xy    (m_tdata),
		.out_last  (m_tlast),
		.out_flags (m_tuser)
	);

endmodule
